### rtl/max_weight_nondecreasing_chain_macros.svh
// ---------------------------------------------------------------------------
// Chain block assertion macros
// Shared property wrappers for the chain block and its pass unit.
// ---------------------------------------------------------------------------
`ifndef MAX_WEIGHT_NONDECREASING_CHAIN_MACROS_SVH
`define MAX_WEIGHT_NONDECREASING_CHAIN_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define MWC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mwc assertion failed");

// Implication checked in the cycle after the antecedent.
`define MWC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mwc assertion failed");

`endif

### rtl/mwc_pkg.sv
// ---------------------------------------------------------------------------
// Chain block package
// Widths, depth and shared types for the chain block.
// ---------------------------------------------------------------------------
package mwc_pkg;
    localparam int MAX_ITEMS   = 256;
    localparam int KEY_BITS    = 10;
    localparam int WEIGHT_BITS = 20;
    localparam int SUM_BITS    = 28;
    localparam int IDX_BITS    = $clog2(MAX_ITEMS);
    localparam int CNT_BITS    = $clog2(MAX_ITEMS + 1);
    localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_PASS,
        ST_DRAIN,
        ST_OUT
    } state_t;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic                ins;    // insertion beat
        logic [KEY_BITS-1:0] key;
        logic [WEIGHT_BITS-1:0] weight;
        logic                shift;  // during the pass, rotate weights one place
        logic                clear;  // end of run
    } cell_ctrl_t;
endpackage

### rtl/mwc_cell.sv
// ---------------------------------------------------------------------------
// Chain cell
// One slot of the sorted row: holds key, weight and a valid flag; on load it
// keeps, takes the new item, or takes its left neighbor (insertion shift).
// During the pass the weights rotate one place toward index zero on each shift.
// ---------------------------------------------------------------------------
module mwc_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mwc_pkg::cell_ctrl_t               ctrl,
    input  logic                              left_valid,
    input  logic                              left_precedes, // new item before left
    input  logic [mwc_pkg::KEY_BITS-1:0]      left_key,
    input  logic [mwc_pkg::WEIGHT_BITS-1:0]   left_weight,
    input  logic [mwc_pkg::WEIGHT_BITS-1:0]   right_weight,
    output logic                              valid,
    output logic                              precedes,      // new item before this
    output logic [mwc_pkg::KEY_BITS-1:0]      key,
    output logic [mwc_pkg::WEIGHT_BITS-1:0]   weight
);
    logic                            valid_reg;
    logic [mwc_pkg::KEY_BITS-1:0]    key_reg, key_next;
    logic [mwc_pkg::WEIGHT_BITS-1:0] weight_reg, weight_next;

    assign precedes = valid_reg &&
        ((ctrl.key < key_reg) || ((ctrl.key == key_reg) && (ctrl.weight < weight_reg)));

    always_comb
    begin
        key_next    = key_reg;
        weight_next = weight_reg;
        if (ctrl.ins)
        begin
            if (left_valid && left_precedes)
            begin
                key_next    = left_key;
                weight_next = left_weight;
            end
            else if (!valid_reg || precedes)
            begin
                key_next    = ctrl.key;
                weight_next = ctrl.weight;
            end
        end
        else if (ctrl.shift)
        begin
            weight_next = right_weight;
        end
    end

    // The new item lands in the first free or first later slot.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ctrl.clear)
            valid_reg <= 1'b0;
        else if (ctrl.ins && left_valid)
            valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        weight_reg <= weight_next;
    end

    assign valid  = valid_reg;
    assign key    = key_reg;
    assign weight = weight_reg;
endmodule

### rtl/mwc_pass.sv
// ---------------------------------------------------------------------------
// Chain pass unit
// Compares the head weight against the held prefix (one prior entry per
// cycle from a sum memory) and keeps the running best.
// ---------------------------------------------------------------------------
`include "max_weight_nondecreasing_chain_macros.svh"
module mwc_pass (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [mwc_pkg::CNT_BITS-1:0]      count,
    input  logic [mwc_pkg::WEIGHT_BITS-1:0]   head_weight,
    output logic                              rotate,
    output logic                              done,
    output logic [mwc_pkg::SUM_BITS-1:0]      best
);
    // Weights of finished entries, indexed by position.
    logic [mwc_pkg::WEIGHT_BITS-1:0] w_mem [mwc_pkg::MAX_ITEMS];
    logic [mwc_pkg::SUM_BITS-1:0]    s_mem [mwc_pkg::MAX_ITEMS];
    logic [mwc_pkg::WEIGHT_BITS-1:0] rd_w_reg;
    logic [mwc_pkg::SUM_BITS-1:0]    rd_s_reg;

    logic                          busy_reg, rd_ok_reg, load_reg;
    logic [mwc_pkg::CNT_BITS-1:0]  i_reg, j_reg;
    logic [mwc_pkg::WEIGHT_BITS-1:0] w_reg;
    logic [mwc_pkg::SUM_BITS-1:0]  cur_reg, best_reg;
    logic                          done_reg;

    logic [mwc_pkg::SUM_BITS:0]    cand;
    logic [mwc_pkg::SUM_BITS-1:0]  cand_sat, cur_upd;
    logic                          inner_end;
    logic                          last_entry;

    assign cand = {1'b0, rd_s_reg} + (mwc_pkg::SUM_BITS+1)'(w_reg);
    assign cand_sat = cand[mwc_pkg::SUM_BITS] ? mwc_pkg::SUM_MAX
                                               : cand[mwc_pkg::SUM_BITS-1:0];
    assign cur_upd = (rd_ok_reg && (w_reg >= rd_w_reg) && (cand_sat > cur_reg))
                     ? cand_sat : cur_reg;
    // Inner loop ends after the last read result is folded in.
    assign inner_end  = busy_reg && (j_reg == i_reg) && !rd_ok_reg;
    assign last_entry = ((i_reg + mwc_pkg::CNT_BITS'(1)) == count);
    assign rotate = inner_end;

    always_ff @(posedge clk)
    begin
        if (busy_reg && (j_reg < i_reg))
        begin
            rd_w_reg <= w_mem[j_reg[mwc_pkg::IDX_BITS-1:0]];
            rd_s_reg <= s_mem[j_reg[mwc_pkg::IDX_BITS-1:0]];
        end
        if (inner_end)
        begin
            w_mem[i_reg[mwc_pkg::IDX_BITS-1:0]] <= w_reg;
            s_mem[i_reg[mwc_pkg::IDX_BITS-1:0]] <= cur_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            rd_ok_reg <= 1'b0;
            load_reg  <= 1'b0;
            done_reg  <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            best_reg  <= '0;
            w_reg     <= '0;
            cur_reg   <= '0;
        end
        else if (start)
        begin
            best_reg  <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            rd_ok_reg <= 1'b0;
            load_reg  <= 1'b0;
            w_reg     <= head_weight;
            cur_reg   <= mwc_pkg::SUM_BITS'(head_weight);
            busy_reg  <= (count != '0);
            done_reg  <= (count == '0);
        end
        else if (busy_reg)
        begin
            rd_ok_reg <= (j_reg < i_reg);
            // Head advanced on the rotate; take its weight on the first cycle.
            if (load_reg)
            begin
                w_reg   <= head_weight;
                cur_reg <= mwc_pkg::SUM_BITS'(head_weight);
            end
            else
                cur_reg <= cur_upd;
            if (inner_end)
            begin
                if (cur_upd > best_reg)
                    best_reg <= cur_upd;
                i_reg    <= i_reg + mwc_pkg::CNT_BITS'(1);
                j_reg    <= '0;
                busy_reg <= !last_entry;
                done_reg <= last_entry;
                load_reg <= !last_entry;
            end
            else
            begin
                if (j_reg < i_reg)
                    j_reg <= j_reg + mwc_pkg::CNT_BITS'(1);
                done_reg <= 1'b0;
                load_reg <= 1'b0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            load_reg <= 1'b0;
        end
    end

    assign done = done_reg;
    assign best = best_reg;

    `MWC_ASSERT_IMP(a_j_bound, busy_reg, j_reg <= i_reg)
    `MWC_ASSERT_NEXT(a_done_pulse, done_reg, !done_reg)
    `MWC_ASSERT_IMP(a_start_idle, start, !busy_reg)
endmodule

### rtl/max_weight_nondecreasing_chain.sv
// ---------------------------------------------------------------------------
// Maximum-weight non-decreasing chain
// Loads (key, weight) beats into a sorted row of cells, then runs a
// quadratic chain pass and emits the best non-decreasing weight sum.
// ---------------------------------------------------------------------------
// Loading takes one beat per cycle: each beat is inserted into a row of
// MAX_ITEMS cells as it is accepted, every cell deciding to keep, take the
// new item or take its left neighbor. Beats beyond MAX_ITEMS are dropped but
// a last flag still starts the pass. After the last beat the input stalls
// while the pass runs: the weights in the row rotate one place per outer
// step and a sum memory is scanned one prior entry per cycle, and s_tready
// stays low until the pass is done. The result waits in an output register,
// so the next set loads while it is held; only a pass that finishes while the
// register is still full holds the input until the sink takes the older beat.
// ---------------------------------------------------------------------------
`include "max_weight_nondecreasing_chain_macros.svh"
module max_weight_nondecreasing_chain (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [9:0] item_key, [29:10] item_weight
    input  logic        s_tlast,   // last_item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [27:0] best_sum
);
    localparam int N = mwc_pkg::MAX_ITEMS;

    mwc_pkg::state_t state_reg, state_next;
    logic [mwc_pkg::CNT_BITS-1:0] count_reg, count_next;
    logic [mwc_pkg::SUM_BITS-1:0] out_reg;
    logic out_valid_reg, out_valid_next;
    logic out_load, out_free;
    mwc_pkg::cell_ctrl_t ctrl;

    logic in_beat, pass_start, pass_done, rotate;
    logic [mwc_pkg::SUM_BITS-1:0] pass_best;

    logic [N-1:0] c_valid, c_precedes;
    logic [mwc_pkg::KEY_BITS-1:0]    c_key [N];
    logic [mwc_pkg::WEIGHT_BITS-1:0] c_weight [N];

    assign s_tready = (state_reg == mwc_pkg::ST_LOAD);
    assign in_beat  = s_tvalid && s_tready;

    assign ctrl.ins    = in_beat && (count_reg != mwc_pkg::CNT_BITS'(N));
    assign ctrl.key    = s_tdata[mwc_pkg::KEY_BITS-1:0];
    assign ctrl.weight = s_tdata[mwc_pkg::KEY_BITS +: mwc_pkg::WEIGHT_BITS];
    assign ctrl.shift  = rotate;
    assign ctrl.clear  = pass_done;

    // Row of cells; cell 0 sees an always-valid left side that never wins.
    for (genvar g = 0; g < N; g++)
    begin : g_cell
        logic lv, lb;
        logic [mwc_pkg::KEY_BITS-1:0]    lk;
        logic [mwc_pkg::WEIGHT_BITS-1:0] lw, rw;
        if (g == 0)
        begin : g_first
            assign lv = 1'b1;
            assign lb = 1'b0;
            assign lk = '0;
            assign lw = '0;
        end
        else
        begin : g_mid
            assign lv = c_valid[g-1];
            assign lb = c_precedes[g-1];
            assign lk = c_key[g-1];
            assign lw = c_weight[g-1];
        end
        assign rw = c_weight[(g + 1) % N];
        mwc_cell u_cell (
            .clk(clk), .rst_n(rst_n), .ctrl(ctrl),
            .left_valid(lv), .left_precedes(lb), .left_key(lk), .left_weight(lw),
            .right_weight(rw),
            .valid(c_valid[g]), .precedes(c_precedes[g]),
            .key(c_key[g]), .weight(c_weight[g])
        );
    end

    assign pass_start = (state_reg == mwc_pkg::ST_PASS);

    mwc_pass u_pass (
        .clk(clk), .rst_n(rst_n), .start(pass_start), .count(count_reg),
        .head_weight(c_weight[0]), .rotate(rotate), .done(pass_done),
        .best(pass_best)
    );

    // The output register is free when empty or when its beat leaves now.
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            mwc_pkg::ST_LOAD:
            begin
                if (ctrl.ins)
                    count_next = count_reg + 1'b1;
                if (in_beat && s_tlast)
                    state_next = mwc_pkg::ST_PASS;
            end
            mwc_pkg::ST_PASS:  state_next = mwc_pkg::ST_DRAIN;
            mwc_pkg::ST_DRAIN:
            begin
                if (pass_done)
                begin
                    count_next = '0;
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        state_next = mwc_pkg::ST_LOAD;
                    end
                    else
                        state_next = mwc_pkg::ST_OUT;
                end
            end
            mwc_pkg::ST_OUT:
            begin
                // Hold the finished sum until the output register frees up.
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = mwc_pkg::ST_LOAD;
                end
            end
            default: state_next = mwc_pkg::ST_LOAD;
        endcase
        out_valid_next = out_load || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mwc_pkg::ST_LOAD;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result until taken.
    always_ff @(posedge clk)
    begin
        if (out_load)
            out_reg <= pass_best;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_reg};

    `MWC_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= mwc_pkg::CNT_BITS'(N))
    `MWC_ASSERT_IMP(a_no_accept_busy, state_reg != mwc_pkg::ST_LOAD, !s_tready)
    `MWC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `MWC_ASSERT_IMP(a_done_in_drain, pass_done, state_reg == mwc_pkg::ST_DRAIN)
endmodule

### tb/tb_max_weight_nondecreasing_chain.sv
// ---------------------------------------------------------------------------
// Chain block testbench
// Streams (key, weight) sets into the chain block and checks each best
// non-decreasing weight sum against a local sorted-store predictor.
// ---------------------------------------------------------------------------
module tb_max_weight_nondecreasing_chain;
    import mwc_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [9:0] item_key, [29:10] item_weight
    logic        s_tlast;   // last_item
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [27:0] best_sum

    max_weight_nondecreasing_chain u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Predictor state: the sorted pair store and its fill count.
    logic [KEY_BITS-1:0]    pair_key [MAX_ITEMS];
    logic [WEIGHT_BITS-1:0] pair_wt  [MAX_ITEMS];
    int                     pair_cnt;
    logic [SUM_BITS-1:0]    best_sums [$];
    int                     mismatches;
    bit                     src_gaps;
    bit                     sink_gaps;
    int                     sink_hold;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50000000;
        $display("Mismatches found");
        $finish;
    end

    // Insert one pair, keeping key then weight ascending; drop when full.
    task automatic store_pair(input logic [KEY_BITS-1:0] k, input logic [WEIGHT_BITS-1:0] w);
        int pos;
        if (pair_cnt >= MAX_ITEMS)
            return;
        pos = pair_cnt;
        while (pos > 0 && (k < pair_key[pos-1] || (k == pair_key[pos-1] && w < pair_wt[pos-1])))
        begin
            pair_key[pos] = pair_key[pos-1];
            pair_wt[pos]  = pair_wt[pos-1];
            pos--;
        end
        pair_key[pos] = k;
        pair_wt[pos]  = w;
        pair_cnt++;
    endtask

    // Quadratic chain pass with saturation at the sum width.
    function automatic logic [SUM_BITS-1:0] best_chain_sum();
        logic [SUM_BITS-1:0] ending [MAX_ITEMS];
        logic [SUM_BITS-1:0] top;
        logic [SUM_BITS:0]   s;
        top = '0;
        for (int i = 0; i < pair_cnt; i++)
        begin
            ending[i] = SUM_BITS'(pair_wt[i]);
            for (int j = 0; j < i; j++)
                if (pair_wt[i] >= pair_wt[j])
                begin
                    s = ending[j] + pair_wt[i];
                    if (s > SUM_MAX)
                        s = SUM_MAX;
                    if (s[SUM_BITS-1:0] > ending[i])
                        ending[i] = s[SUM_BITS-1:0];
                end
            if (ending[i] > top)
                top = ending[i];
        end
        return top;
    endfunction

    // Send one beat; predict once it is accepted. Valid stays up afterwards
    // and drops only for a gap or when the source goes idle.
    task automatic send_pair(input logic [KEY_BITS-1:0] k, input logic [WEIGHT_BITS-1:0] w,
                             input logic lst);
        int gap;
        if (src_gaps && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 11);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b0, w, k};
        s_tlast  <= lst;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        store_pair(k, w);
        if (lst)
        begin
            best_sums.insert(best_sums.size(), best_chain_sum());
            pair_cnt = 0;
        end
    endtask

    // Idle the source until every expected result has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (best_sums.size() != 0);
    endtask

    // Random set; mostly small, occasionally near the store depth.
    task automatic send_random_set(input int n, input bit big_wt);
        logic [WEIGHT_BITS-1:0] w;
        for (int i = 0; i < n; i++)
        begin
            w = big_wt ? WEIGHT_BITS'($urandom_range(1048000, 1048575))
                       : WEIGHT_BITS'($urandom);
            if ($urandom_range(0, 3) == 0)
                w = WEIGHT_BITS'($urandom_range(0, 15));
            send_pair(KEY_BITS'($urandom_range(0, 3) == 0 ? $urandom_range(0, 7) : $urandom),
                      w, i == n - 1);
        end
    endtask

    task automatic test_directed();
        // Single item, all-zero and all-ones fields.
        send_pair('0, '0, 1'b1);
        send_pair('1, '1, 1'b1);
        // Equal keys, weight breaks ties; decreasing weights in key order.
        send_pair(10'd5, 20'd9, 1'b0);
        send_pair(10'd5, 20'd3, 1'b0);
        send_pair(10'd1, 20'd7, 1'b0);
        send_pair(10'd2, 20'd4, 1'b1);
        // Largest sum: a full store of max weights with equal keys.
        for (int i = 0; i < 300; i++)
            send_pair(10'd0, '1, 1'b0);
        send_pair(10'd0, '1, 1'b1);   // store full: dropped, still closes the set
        wait_drained();
    endtask

    task automatic test_random();
        int n;
        for (int s = 0; s < 100; s++)
        begin
            n = (s % 50 == 25) ? $urandom_range(100, 260) : $urandom_range(1, 6);
            send_random_set(n, $urandom_range(0, 7) == 0);
        end
    endtask

    // Hold the sink off while the source keeps offering sets.
    task automatic test_backpressure();
        sink_hold = 400;
        send_random_set(3, 1'b0);
        send_random_set(3, 1'b0);
        send_random_set(2, 1'b0);
        wait_drained();   // pause source until everything is out
        send_random_set(4, 1'b0);
    endtask

    task automatic test_no_gaps();
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        for (int s = 0; s < 40; s++)
            send_random_set($urandom_range(1, 6), 1'b0);
    endtask

    // Sink: random stalls, long hold on request, checks every result beat.
    initial
    begin
        int gap;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (sink_hold > 0)
            begin
                m_tready <= 1'b0;
                sink_hold--;
            end
            else if (sink_gaps && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 11);
                m_tready <= 1'b0;
                repeat (gap - 1) @(posedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (best_sums.size() == 0)
            begin
                $error("best_sum: unexpected result %0d", m_tdata[SUM_BITS-1:0]);
                mismatches++;
            end
            else
            begin
                if (m_tdata[SUM_BITS-1:0] !== best_sums[0])
                begin
                    $error("best_sum: expected %0d actual %0d", best_sums[0],
                           m_tdata[SUM_BITS-1:0]);
                    mismatches++;
                end
                void'(best_sums.pop_front());
            end
        end
    end

    initial
    begin
        mismatches = 0;
        pair_cnt   = 0;
        sink_hold  = 0;
        src_gaps   = 1'b1;
        sink_gaps  = 1'b1;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        test_backpressure();
        test_no_gaps();
        wait_drained();
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
